/* hdl/cbu_pkg.sv */
// Shared types, codes and helper functions of the color blend unit.
package cbu_pkg;

	localparam int unsigned PixW = 32;
	localparam int unsigned ChanW = 8;
	localparam int unsigned NumChan = 4;
	localparam int unsigned AlphaChan = 3;

	// Blend equation codes.
	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_RSUB = 3'd2;
	localparam logic [2:0] MODE_MIN = 3'd3;
	localparam logic [2:0] MODE_MAX = 3'd4;
	localparam logic [2:0] MODE_LOGIC = 3'd5;

	// Factor select codes.
	localparam logic [3:0] FAC_ZERO = 4'd0;
	localparam logic [3:0] FAC_ONE = 4'd1;
	localparam logic [3:0] FAC_SRC = 4'd2;
	localparam logic [3:0] FAC_INV_SRC = 4'd3;
	localparam logic [3:0] FAC_DST = 4'd4;
	localparam logic [3:0] FAC_INV_DST = 4'd5;
	localparam logic [3:0] FAC_SRC_A = 4'd6;
	localparam logic [3:0] FAC_INV_SRC_A = 4'd7;
	localparam logic [3:0] FAC_DST_A = 4'd8;
	localparam logic [3:0] FAC_INV_DST_A = 4'd9;
	localparam logic [3:0] FAC_CONST = 4'd10;
	localparam logic [3:0] FAC_INV_CONST = 4'd11;
	localparam logic [3:0] FAC_CONST_A = 4'd12;
	localparam logic [3:0] FAC_INV_CONST_A = 4'd13;
	localparam logic [3:0] FAC_ALPHA_SAT = 4'd14;

	// Logic operation codes.
	localparam logic [3:0] LOP_CLEAR = 4'd0;
	localparam logic [3:0] LOP_AND = 4'd1;
	localparam logic [3:0] LOP_AND_REV = 4'd2;
	localparam logic [3:0] LOP_COPY = 4'd3;
	localparam logic [3:0] LOP_AND_INV = 4'd4;
	localparam logic [3:0] LOP_NOOP = 4'd5;
	localparam logic [3:0] LOP_XOR = 4'd6;
	localparam logic [3:0] LOP_OR = 4'd7;
	localparam logic [3:0] LOP_NOR = 4'd8;
	localparam logic [3:0] LOP_EQUIV = 4'd9;
	localparam logic [3:0] LOP_INVERT = 4'd10;
	localparam logic [3:0] LOP_OR_REV = 4'd11;
	localparam logic [3:0] LOP_COPY_INV = 4'd12;
	localparam logic [3:0] LOP_OR_INV = 4'd13;
	localparam logic [3:0] LOP_NAND = 4'd14;
	localparam logic [3:0] LOP_SET = 4'd15;

	// Configuration register indexes.
	localparam logic [2:0] REG_COLOR_MODE = 3'd0;
	localparam logic [2:0] REG_ALPHA_MODE = 3'd1;
	localparam logic [2:0] REG_SRC_COLOR_FACTOR = 3'd2;
	localparam logic [2:0] REG_SRC_ALPHA_FACTOR = 3'd3;
	localparam logic [2:0] REG_DST_COLOR_FACTOR = 3'd4;
	localparam logic [2:0] REG_DST_ALPHA_FACTOR = 3'd5;
	localparam logic [2:0] REG_BLEND_CONSTANT = 3'd6;
	localparam logic [2:0] REG_LOGIC_OPERATION = 3'd7;

	localparam logic [15:0] ROUND_BIAS = 16'h0080;
	localparam logic [16:0] ADD_CLAMP = 17'h0FF00;
	localparam logic [7:0] CHAN_ONE = 8'hff;
	localparam logic [31:0] WORD_ONES = 32'hffffffff;

	typedef struct packed {
		logic [2:0] color_mode;
		logic [2:0] alpha_mode;
		logic [3:0] src_color_factor;
		logic [3:0] src_alpha_factor;
		logic [3:0] dst_color_factor;
		logic [3:0] dst_alpha_factor;
		logic [31:0] blend_constant;
		logic [3:0] logic_operation;
	} cfg_t;

	// Per-channel operands and weighted products.
	typedef struct packed {
		logic [7:0] s;
		logic [7:0] d;
		logic [15:0] ps;
		logic [15:0] pd;
	} prod_t;

	typedef prod_t [NumChan-1:0] prod_arr_t;

	function automatic logic [7:0] weight_f(input logic [3:0] sel, input logic is_alpha,
			input logic [7:0] sc, input logic [7:0] dc, input logic [7:0] cc,
			input logic [7:0] sa, input logic [7:0] da, input logic [7:0] ca);
		logic [7:0] w;
		logic [7:0] inv_da;
		inv_da = CHAN_ONE - da;
		case (sel)
			FAC_ZERO: w = '0;
			FAC_ONE: w = CHAN_ONE;
			FAC_SRC: w = sc;
			FAC_INV_SRC: w = CHAN_ONE - sc;
			FAC_DST: w = dc;
			FAC_INV_DST: w = CHAN_ONE - dc;
			FAC_SRC_A: w = sa;
			FAC_INV_SRC_A: w = CHAN_ONE - sa;
			FAC_DST_A: w = da;
			FAC_INV_DST_A: w = inv_da;
			FAC_CONST: w = cc;
			FAC_INV_CONST: w = CHAN_ONE - cc;
			FAC_CONST_A: w = ca;
			FAC_INV_CONST_A: w = CHAN_ONE - ca;
			FAC_ALPHA_SAT: begin
				if (is_alpha) w = CHAN_ONE;
				else w = (sa < inv_da) ? sa : inv_da;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] logic_f(input logic [3:0] op, input logic [31:0] s,
			input logic [31:0] d);
		logic [31:0] r;
		case (op)
			LOP_CLEAR: r = '0;
			LOP_AND: r = s & d;
			LOP_AND_REV: r = s & ~d;
			LOP_COPY: r = s;
			LOP_AND_INV: r = ~s & d;
			LOP_NOOP: r = d;
			LOP_XOR: r = s ^ d;
			LOP_OR: r = s | d;
			LOP_NOR: r = ~(s | d);
			LOP_EQUIV: r = ~(s ^ d);
			LOP_INVERT: r = ~d;
			LOP_OR_REV: r = s | ~d;
			LOP_COPY_INV: r = ~s;
			LOP_OR_INV: r = ~s | d;
			LOP_NAND: r = ~(s & d);
			LOP_SET: r = WORD_ONES;
			default: r = WORD_ONES;
		endcase
		return r;
	endfunction

	// Approximate division by 255 of a value below 2^16.
	function automatic logic [7:0] div255_f(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]};
		return t[15:8];
	endfunction

endpackage

/* hdl/cbu_product.sv */
// Factor selection and weighted products for all four channels, registered.
module cbu_product import cbu_pkg::*; (
	input logic clk,
	input logic en,
	input logic [31:0] src,
	input logic [31:0] dst,
	input cfg_t cfg,
	output prod_arr_t prod_s2,
	output logic [31:0] lword_s2
);

	prod_arr_t prod_d;

	always_comb begin
		logic [7:0] sc, dc, cc, f, g;
		logic [3:0] fsel, gsel;
		logic is_alpha;
		for (int ch = 0; ch < NumChan; ch++) begin
			is_alpha = (ch == AlphaChan);
			sc = src[ch*ChanW +: ChanW];
			dc = dst[ch*ChanW +: ChanW];
			cc = cfg.blend_constant[ch*ChanW +: ChanW];
			fsel = is_alpha ? cfg.src_alpha_factor : cfg.src_color_factor;
			gsel = is_alpha ? cfg.dst_alpha_factor : cfg.dst_color_factor;
			f = weight_f(fsel, is_alpha, sc, dc, cc, src[31:24], dst[31:24],
				cfg.blend_constant[31:24]);
			g = weight_f(gsel, is_alpha, sc, dc, cc, src[31:24], dst[31:24],
				cfg.blend_constant[31:24]);
			prod_d[ch].s = sc;
			prod_d[ch].d = dc;
			prod_d[ch].ps = sc * f;
			prod_d[ch].pd = dc * g;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod_d;
			lword_s2 <= logic_f(cfg.logic_operation, src, dst);
		end
	end

endmodule

/* hdl/cbu_combine.sv */
// Blend equations per channel and the result register.
module cbu_combine import cbu_pkg::*; (
	input logic clk,
	input logic en,
	input prod_arr_t prod,
	input logic [31:0] lword,
	input cfg_t cfg,
	output logic [31:0] pixel_q
);

	logic [31:0] pixel_d;

	always_comb begin
		logic [2:0] mode;
		logic [16:0] sum;
		logic signed [17:0] diff;
		logic [15:0] x;
		logic [7:0] r;
		for (int ch = 0; ch < NumChan; ch++) begin
			mode = (ch == AlphaChan) ? cfg.alpha_mode : cfg.color_mode;
			sum = {1'b0, prod[ch].ps} + {1'b0, prod[ch].pd} + {1'b0, ROUND_BIAS};
			if (mode == MODE_RSUB)
				diff = $signed({2'b00, prod[ch].pd}) - $signed({2'b00, prod[ch].ps})
					+ $signed({2'b00, ROUND_BIAS});
			else
				diff = $signed({2'b00, prod[ch].ps}) - $signed({2'b00, prod[ch].pd})
					+ $signed({2'b00, ROUND_BIAS});
			if (mode == MODE_ADD)
				x = (sum > ADD_CLAMP) ? ADD_CLAMP[15:0] : sum[15:0];
			else
				x = diff[17] ? 16'd0 : diff[15:0];
			case (mode) inside
				MODE_ADD, MODE_SUB, MODE_RSUB: r = div255_f(x);
				MODE_MIN: r = (prod[ch].s < prod[ch].d) ? prod[ch].s : prod[ch].d;
				MODE_MAX: r = (prod[ch].s > prod[ch].d) ? prod[ch].s : prod[ch].d;
				MODE_LOGIC: r = lword[ch*ChanW +: ChanW];
				default: r = '0;
			endcase
			pixel_d[ch*ChanW +: ChanW] = r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) pixel_q <= pixel_d;
	end

endmodule

/* hdl/color_blend_unit_top.sv */
// Top level of the color blend unit: configuration registers and pipeline control.
//
// Blends a source and a destination ARGB8888 pixel into one result pixel.
// Input channel s_*: s_tdata holds source_pixel in bits 31:0 and dest_pixel in
// bits 63:32. Output channel m_*: m_tdata holds blended_pixel.
// The configuration port writes register cfg_index with cfg_data whenever
// cfg_we is high; write it only while no pixel is in flight.
// A pixel passes three register stages: an input register, the product
// register after the 8x8 weight multipliers, and the result register. The
// result is offered from the result register, and one pixel transfer is
// taken every cycle while the receiver keeps m_tready high.
// When the receiver stalls, the pipeline fills its empty stages and then
// drops s_tready; each stage moves forward as soon as the one after it moves.
// Reset empties the pipeline and loads the register defaults: add equation
// for both groups, source factors one, destination factors zero, constant
// zero and logic operation copy.
module color_blend_unit_top import cbu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [63:0] s_tdata, // source_pixel [31:0], dest_pixel [63:32]
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // blended_pixel [31:0]
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);

	cfg_t cfg_q;
	logic v1_q, v2_q, vo_q;
	logic adv1, adv2, advo;
	logic [31:0] src_s1, dst_s1;
	prod_arr_t prod_s2;
	logic [31:0] lword_s2;

	assign advo = !vo_q || m_tready;
	assign adv2 = !v2_q || advo;
	assign adv1 = !v1_q || adv2;
	assign s_tready = adv1;
	assign m_tvalid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_mode <= MODE_ADD;
			cfg_q.alpha_mode <= MODE_ADD;
			cfg_q.src_color_factor <= FAC_ONE;
			cfg_q.src_alpha_factor <= FAC_ONE;
			cfg_q.dst_color_factor <= FAC_ZERO;
			cfg_q.dst_alpha_factor <= FAC_ZERO;
			cfg_q.blend_constant <= '0;
			cfg_q.logic_operation <= LOP_COPY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLOR_MODE: cfg_q.color_mode <= cfg_data[2:0];
				REG_ALPHA_MODE: cfg_q.alpha_mode <= cfg_data[2:0];
				REG_SRC_COLOR_FACTOR: cfg_q.src_color_factor <= cfg_data[3:0];
				REG_SRC_ALPHA_FACTOR: cfg_q.src_alpha_factor <= cfg_data[3:0];
				REG_DST_COLOR_FACTOR: cfg_q.dst_color_factor <= cfg_data[3:0];
				REG_DST_ALPHA_FACTOR: cfg_q.dst_alpha_factor <= cfg_data[3:0];
				REG_BLEND_CONSTANT: cfg_q.blend_constant <= cfg_data;
				REG_LOGIC_OPERATION: cfg_q.logic_operation <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= s_tvalid;
			if (adv2) v2_q <= v1_q;
			if (advo) vo_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			src_s1 <= s_tdata[31:0];
			dst_s1 <= s_tdata[63:32];
		end
	end

	cbu_product u_product (
		.clk(clk),
		.en(adv2),
		.src(src_s1),
		.dst(dst_s1),
		.cfg(cfg_q),
		.prod_s2(prod_s2),
		.lword_s2(lword_s2)
	);

	cbu_combine u_combine (
		.clk(clk),
		.en(advo),
		.prod(prod_s2),
		.lword(lword_s2),
		.cfg(cfg_q),
		.pixel_q(m_tdata)
	);

endmodule
